// ===== src/mspc_pkg.sv =====
// Package for the motor speed PID controller.
// Holds item kinds, register indexes, field types and shared constants.
`timescale 1ns / 1ps
package mspc_pkg;
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_SET  = 2'd1,
    KIND_STOP = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_KP = 3'd0, REG_KI = 3'd1, REG_KD = 3'd2, REG_KF = 3'd3,
    REG_IBOUND = 3'd4, REG_FULLSCALE = 3'd5, REG_DRIVELIM = 3'd6, REG_DIRFLAGS = 3'd7
  } reg_e;

  localparam int unsigned CfgIdxW = 32;
  localparam int unsigned AluW = 50;
  localparam logic [14:0] DriveLimitCap = 15'd16384;
  localparam logic [31:0] DefaultDt = 32'd10;
  // The quotient by 100 is the product with ceil(2^29 / 100), shifted right by 29.
  localparam logic [22:0] RecipHundred = 23'd5368710;
  localparam int unsigned RecipShift = 29;

  typedef struct packed {
    logic [1:0]        kind;
    logic [31:0]       now_ms;
    logic signed [15:0] measured_rpm;
    logic [7:0]        speed_request;
    logic              reverse_request;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              drive_valid;
    logic signed [15:0] drive_current;
    logic [6:0]        speed_now;
    logic              reverse_now;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_item_t;

  // Start and handshake of the shared multiply/divide unit.
  typedef struct packed {
    logic                    start;
    logic                    is_div;
    logic signed [AluW-1:0]  a;
    logic signed [AluW-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [2*AluW-1:0] result;
  } alu_rsp_t;
endpackage

// ===== src/mspc_if.sv =====
// Valid/ready channel interface carrying one payload struct.
// Depends on mspc_pkg for the payload types.
`timescale 1ns / 1ps
interface mspc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/mspc_alu.sv =====
// Shared iterative unit: shift-add signed multiply or restoring signed divide.
// One bit per cycle. Depends on mspc_pkg.
`timescale 1ns / 1ps
module mspc_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mspc_pkg::alu_req_t  req_i,
  output mspc_pkg::alu_rsp_t  rsp_o
);
  import mspc_pkg::*;
  localparam int unsigned W = AluW;

  logic              busy_q, busy_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              div_q, div_d;
  logic              neg_q, neg_d;
  logic [W-1:0]      ua_q, ua_d;
  logic [W-1:0]      ub_q, ub_d;
  logic [2*W-1:0]    acc_q, acc_d;
  logic [W-1:0]      rem_q, rem_d;
  logic              done_q, done_d;
  logic [W-1:0]      abs_a, abs_b;
  logic [W:0]        trial;
  logic [W-1:0]      rem_sh;

  assign abs_a = req_i.a[W-1] ? W'(-req_i.a) : W'(req_i.a);
  assign abs_b = req_i.b[W-1] ? W'(-req_i.b) : W'(req_i.b);
  assign rem_sh = {rem_q[W-2:0], ua_q[W-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, ub_q};

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; div_d = div_q; neg_d = neg_q;
    ua_d = ua_q; ub_d = ub_q; acc_d = acc_q; rem_d = rem_q; done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1; cnt_d = 6'(W); div_d = req_i.is_div;
      neg_d = req_i.a[W-1] ^ req_i.b[W-1];
      ua_d = abs_a; ub_d = abs_b; acc_d = '0; rem_d = '0;
    end else if (busy_q) begin
      if (div_q) begin
        ua_d = {ua_q[W-2:0], 1'b0};
        if (!trial[W]) begin
          rem_d = trial[W-1:0];
          acc_d = {acc_q[2*W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          acc_d = {acc_q[2*W-2:0], 1'b0};
        end
      end else begin
        acc_d = ub_q[0] ? acc_q + ({{W{1'b0}}, ua_q} << (6'(W) - cnt_q)) : acc_q;
        ub_d = {1'b0, ub_q[W-1:1]};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d; neg_q <= neg_d; ua_q <= ua_d; ub_q <= ub_d;
    acc_q <= acc_d; rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.result = neg_q ? -$signed(acc_q) : $signed(acc_q);
endmodule

// ===== src/mspc_regs.sv =====
// Configuration register file written through the config channel.
// Depends on mspc_pkg and mspc_stream_if.
`timescale 1ns / 1ps
module mspc_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  mspc_stream_if.sink        cfg,
  output logic signed [31:0] kp_o,
  output logic signed [31:0] ki_o,
  output logic signed [31:0] kd_o,
  output logic signed [31:0] kf_o,
  output logic [31:0]        ibound_o,
  output logic [14:0]        fullscale_o,
  output logic [14:0]        drivelim_o,
  output logic [1:0]         dirflags_o
);
  import mspc_pkg::*;
  logic wr;
  assign cfg.ready = 1'b1;
  assign wr = cfg.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_o <= '0; ki_o <= '0; kd_o <= '0; kf_o <= '0; ibound_o <= '0;
      fullscale_o <= '0; drivelim_o <= '0; dirflags_o <= '0;
    end else if (wr && cfg.data.index < CfgIdxW'(8)) begin
      unique case (reg_e'(cfg.data.index[2:0]))
        REG_KP:        kp_o <= cfg.data.data;
        REG_KI:        ki_o <= cfg.data.data;
        REG_KD:        kd_o <= cfg.data.data;
        REG_KF:        kf_o <= cfg.data.data;
        REG_IBOUND:    ibound_o <= cfg.data.data;
        REG_FULLSCALE: fullscale_o <= cfg.data.data[14:0];
        REG_DRIVELIM:  drivelim_o <= cfg.data.data[14:0];
        REG_DIRFLAGS:  dirflags_o <= cfg.data.data[1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== src/motor_speed_pid_controller_top.sv =====
// Top level of the motor speed PID controller: sequencer, state and output.
// Depends on mspc_pkg, mspc_stream_if, mspc_regs and mspc_alu.
`timescale 1ns / 1ps
// Usage: items enter on the input channel (kind, time stamp, measured rpm,
// speed percent, direction); each item gives exactly one result transfer on
// the output channel. Gains and limits are written on the config channel
// while the block is idle; the block itself does not enforce this, the user must.
// The gain products, the reciprocal multiply and the divide by dt run one bit
// per cycle through the shared 50-bit unit.
// A set-speed item with a valid percent needs one multiply by the reciprocal
// of 100; its result is offered once that multiply is done.
// A tick that runs the PID step needs four multiplies and one divide before
// its result is offered; the first step after a clear has no derivative term
// and needs only three multiplies and no divide.
// Stop, rejected and skipped items are offered from the dispatch state without the shared unit.
// Input ready is low from acceptance until the result is transferred and
// returns the cycle after, so a stalled receiver holds the block.
// After reset all gains, limits and controller state are zero.
module motor_speed_pid_controller_top #(
  parameter int unsigned TASK_PERIOD_MS = 10,
  parameter int unsigned MAX_DT_MS = 200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mspc_stream_if.sink   in_ch,
  mspc_stream_if.source out_ch,
  mspc_stream_if.sink   cfg
);
  import mspc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_DISP = 10'b0000000010, S_DIV  = 10'b0000000100,
    S_PMUL = 10'b0000001000, S_IMUL = 10'b0000010000, S_DMUL = 10'b0000100000,
    S_DDIV = 10'b0001000000, S_FMUL = 10'b0010000000, S_SAT  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  localparam logic signed [63:0] TermClamp = 64'sd1 <<< 60;

  state_e state_q;
  logic signed [31:0] kp, ki, kd, kf;
  logic [31:0] ibound;
  logic [14:0] fullscale, drivelim;
  logic [1:0] dirflags;
  alu_req_t req;
  alu_rsp_t rsp;
  in_item_t it_q;
  out_item_t res_q;

  logic [6:0] pct_q;
  logic rev_q;
  logic signed [15:0] target_q;
  logic signed [33:0] integ_q;
  logic signed [17:0] perr_q;
  logic [31:0] ppid_q, ptask_q;
  logic started_q;
  logic signed [15:0] held_q;
  logic signed [17:0] err_q;
  logic [13:0] dt_q;
  logic signed [63:0] sum_q;
  logic signed [18:0] derr_q;
  logic signed [63:0] dmul_q;
  logic launch_q;

  mspc_regs u_regs (
    .clk_i, .rst_ni, .cfg,
    .kp_o(kp), .ki_o(ki), .kd_o(kd), .kf_o(kf), .ibound_o(ibound),
    .fullscale_o(fullscale), .drivelim_o(drivelim), .dirflags_o(dirflags)
  );

  mspc_alu u_alu (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  function automatic logic signed [63:0] clampt(input logic signed [2*AluW-1:0] v);
    if (v > (2*AluW)'(TermClamp)) return TermClamp;
    if (v < -(2*AluW)'(TermClamp)) return -TermClamp;
    return 64'(v);
  endfunction

  logic signed [16:0] meas_eff;
  logic signed [17:0] err_c;
  logic [31:0] dpid, dtask;
  logic signed [34:0] integ_new;
  logic signed [34:0] ib_s;
  logic signed [63:0] q_c;
  logic signed [15:0] q16, lim16;
  logic [14:0] lim;
  logic [22:0] pct_fs;
  logic signed [15:0] quot16;

  assign meas_eff = dirflags[1] ? -17'(it_q.measured_rpm) : 17'(it_q.measured_rpm);
  assign err_c = 18'(target_q) - 18'(meas_eff);
  assign dpid = it_q.now_ms - ppid_q;
  assign dtask = it_q.now_ms - ptask_q;
  assign ib_s = $signed({3'b0, ibound});
  assign integ_new = 35'(integ_q) + 35'(err_q) * 35'($signed({1'b0, dt_q}));
  assign q_c = sum_q / 64'sd65536;
  assign lim = drivelim > DriveLimitCap ? DriveLimitCap : drivelim;
  assign lim16 = $signed({1'b0, lim});
  assign pct_fs = 23'(it_q.speed_request) * 23'(fullscale);
  assign quot16 = $signed(rsp.result[RecipShift +: 16]);
  always_comb begin
    q16 = q_c > 64'sd32767 ? 16'sh7fff : (q_c < -64'sd32768 ? 16'sh8000 : 16'(q_c));
    if (q16 > lim16) q16 = lim16;
    else if (q16 < -lim16) q16 = -lim16;
  end

  assign in_ch.ready = state_q == S_IDLE;
  assign out_ch.valid = state_q == S_OUT;
  assign out_ch.data = res_q;

  always_comb begin
    req = '0;
    req.start = launch_q;
    unique case (state_q)
      S_DIV:  begin req.a = AluW'(pct_fs); req.b = AluW'(RecipHundred); end
      S_PMUL: begin req.a = AluW'(err_q); req.b = AluW'(kp); end
      S_IMUL: begin req.a = AluW'(integ_q); req.b = AluW'(ki); end
      S_DMUL: begin req.a = AluW'(derr_q); req.b = AluW'(kd); end
      S_DDIV: begin req.is_div = 1'b1; req.a = AluW'(dmul_q); req.b = AluW'(dt_q); end
      S_FMUL: begin req.a = AluW'(target_q); req.b = AluW'(kf); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pct_q <= '0; rev_q <= 1'b0; target_q <= '0; integ_q <= '0;
      perr_q <= '0; ppid_q <= '0; ptask_q <= '0; started_q <= 1'b0; held_q <= '0;
      launch_q <= 1'b0; err_q <= '0; dt_q <= '0; sum_q <= '0; derr_q <= '0;
      dmul_q <= '0; it_q <= '0; res_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          launch_q <= 1'b0;
          if (in_ch.valid) begin
            it_q <= in_ch.data; state_q <= S_DISP;
          end
        end
        S_DISP: begin
          priority if (it_q.kind == KIND_STOP ||
                       (it_q.kind == KIND_SET && it_q.speed_request == 8'd0)) begin
            pct_q <= '0; target_q <= '0; held_q <= '0; integ_q <= '0; perr_q <= '0;
            ppid_q <= '0; started_q <= 1'b0;
            res_q <= '{status: 1'b0, drive_valid: 1'b1, drive_current: 16'sd0,
                       speed_now: 7'd0, reverse_now: rev_q};
            launch_q <= 1'b0; state_q <= S_OUT;
          end else if (it_q.kind == KIND_BAD ||
                       (it_q.kind == KIND_SET && it_q.speed_request > 8'd100)) begin
            res_q <= '{status: 1'b1, drive_valid: 1'b0, drive_current: held_q,
                       speed_now: pct_q, reverse_now: rev_q};
            launch_q <= 1'b0; state_q <= S_OUT;
          end else if (it_q.kind == KIND_SET) begin
            launch_q <= 1'b1; state_q <= S_DIV;
          end else if (pct_q != '0 && dtask >= 32'(TASK_PERIOD_MS)) begin
            ptask_q <= it_q.now_ms;
            err_q <= err_c;
            if (started_q && dpid > 32'd0 && dpid < 32'(MAX_DT_MS))
              dt_q <= dpid[13:0];
            else dt_q <= DefaultDt[13:0];
            derr_q <= 19'(err_c) - 19'(perr_q);
            state_q <= S_PMUL; launch_q <= 1'b1;
          end else begin
            res_q <= '{status: 1'b0, drive_valid: 1'b0, drive_current: held_q,
                       speed_now: pct_q, reverse_now: rev_q};
            launch_q <= 1'b0; state_q <= S_OUT;
          end
        end
        S_DIV: begin
          launch_q <= 1'b0;
          if (rsp.done) begin
            target_q <= (it_q.reverse_request ^ dirflags[0]) ? -quot16 : quot16;
            if (7'(it_q.speed_request) != pct_q || it_q.reverse_request != rev_q) begin
              integ_q <= '0; perr_q <= '0; ppid_q <= '0; started_q <= 1'b0;
            end
            pct_q <= 7'(it_q.speed_request); rev_q <= it_q.reverse_request;
            res_q <= '{status: 1'b0, drive_valid: 1'b0, drive_current: held_q,
                       speed_now: 7'(it_q.speed_request),
                       reverse_now: it_q.reverse_request};
            state_q <= S_OUT;
          end
        end
        S_PMUL: begin
          launch_q <= rsp.done;
          if (rsp.done) begin
            sum_q <= clampt(rsp.result);
            if (integ_new > ib_s) integ_q <= 34'(ib_s);
            else if (integ_new < -ib_s) integ_q <= 34'(-ib_s);
            else integ_q <= 34'(integ_new);
            perr_q <= err_q; ppid_q <= it_q.now_ms;
            state_q <= S_IMUL;
          end
        end
        S_IMUL: begin
          launch_q <= rsp.done;
          if (rsp.done) begin
            sum_q <= sum_q + clampt(rsp.result);
            if (started_q) state_q <= S_DMUL;
            else state_q <= S_FMUL;
            started_q <= 1'b1;
          end
        end
        S_DMUL: begin
          launch_q <= rsp.done;
          if (rsp.done) begin
            dmul_q <= 64'(rsp.result);
            state_q <= S_DDIV;
          end
        end
        S_DDIV: begin
          launch_q <= rsp.done;
          if (rsp.done) begin
            sum_q <= sum_q + clampt(rsp.result);
            state_q <= S_FMUL;
          end
        end
        S_FMUL: begin
          launch_q <= 1'b0;
          if (rsp.done) begin
            sum_q <= sum_q + clampt(rsp.result);
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          launch_q <= 1'b0;
          held_q <= q16;
          res_q <= '{status: 1'b0, drive_valid: 1'b1, drive_current: q16,
                     speed_now: pct_q, reverse_now: rev_q};
          state_q <= S_OUT;
        end
        S_OUT: begin
          launch_q <= 1'b0;
          if (out_ch.ready) state_q <= S_IDLE;
        end
        default: begin
          launch_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== src/mspc_checker.sv =====
// Port-level checker for the motor speed PID controller, bound to the top.
// Depends on mspc_pkg and mspc_stream_if.
`timescale 1ns / 1ps
module mspc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_status,
  input logic out_drive_valid,
  input logic [6:0] out_speed_now
);
  import mspc_pkg::*;
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready && out_valid))
    else $error("input ready while a result waits");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("input ready right after a transfer");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_speed_now <= 7'd100) else $error("speed out of range");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status |-> !out_drive_valid) else $error("rejected item drove");
endmodule

bind motor_speed_pid_controller_top mspc_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.data.status),
  .out_drive_valid(out_ch.data.drive_valid), .out_speed_now(out_ch.data.speed_now)
);
